// File: sv/kpva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpva_pkg: shared types and constants of the Kalman tracker
// Word format, operation codes, the shared unit's command set and helpers.
// ----------------------------------------------------------------------------
package kpva_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int WORD_W        = 32;
    localparam int NOISE_W       = 31;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_PREDICT = 2'd0,
        OP_UPD_VEL = 2'd1,
        OP_UPD_ACC = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_NOISE_POS = 2'd0,
        CFG_NOISE_VEL = 2'd1,
        CFG_NOISE_ACC = 2'd2
    } cfg_idx_t;

    // Operation of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic                      start;
        alu_op_t                   op;
        logic signed [WORD_W-1:0]  a;
        logic signed [WORD_W-1:0]  b;
    } alu_req_t;

    function automatic logic signed [WORD_W-1:0] sat64(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'(WORD_MAX);
        lo = 64'(WORD_MIN);
        if (v > hi)
            return WORD_MAX;
        else if (v < lo)
            return WORD_MIN;
        else
            return v[WORD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/kpva_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpva_alu: shared saturating arithmetic unit
// Saturating add, subtract and fixed-point multiply, result registered.
// ----------------------------------------------------------------------------
module kpva_alu (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire kpva_pkg::alu_req_t               req,
    output logic signed [kpva_pkg::WORD_W-1:0]    result
);

    logic signed [kpva_pkg::WORD_W-1:0] result_next;
    logic signed [63:0]                 prod;
    logic signed [63:0]                 shifted;
    logic signed [63:0]                 wide_sum;

    always_comb
    begin
        prod    = 64'(req.a) * 64'(req.b);
        // Arithmetic shift rounds toward minus infinity, as required.
        shifted = prod >>> kpva_pkg::FRACTION_BITS;
        unique case (req.op)
            kpva_pkg::ALU_ADD: wide_sum = 64'(req.a) + 64'(req.b);
            kpva_pkg::ALU_SUB: wide_sum = 64'(req.a) - 64'(req.b);
            kpva_pkg::ALU_MUL: wide_sum = shifted;
            default:           wide_sum = 64'(req.a);
        endcase
        result_next = kpva_pkg::sat64(wide_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result <= '0;
        end
        else if (req.start)
        begin
            result <= result_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/kpva_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpva_div: iterative signed divider for the Kalman gain
// Computes sat((num << FRACTION_BITS) / den), truncating toward zero,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kpva_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic signed [kpva_pkg::WORD_W-1:0] num,
    input  wire logic signed [kpva_pkg::WORD_W-1:0] den,
    output logic                                  done,
    output logic signed [kpva_pkg::WORD_W-1:0]    quot
);

    localparam int DW = kpva_pkg::WORD_W + kpva_pkg::FRACTION_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]   dvd_reg;
    logic [DW-1:0]   q_reg;
    logic [DW:0]     rem_reg;
    logic [kpva_pkg::WORD_W-1:0] dvs_reg;
    logic            neg_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;

    logic [DW:0]     rem_sh;
    logic [DW:0]     rem_try;
    logic [DW-1:0]   num_mag;
    logic [kpva_pkg::WORD_W-1:0] den_mag;
    logic signed [63:0] q_signed;

    always_comb
    begin
        num_mag = num[kpva_pkg::WORD_W-1]
                ? DW'(-{{kpva_pkg::FRACTION_BITS{num[kpva_pkg::WORD_W-1]}}, num})
                    << kpva_pkg::FRACTION_BITS
                : DW'({{kpva_pkg::FRACTION_BITS{1'b0}}, num}) << kpva_pkg::FRACTION_BITS;
        den_mag = den[kpva_pkg::WORD_W-1] ? -den : den;
        rem_sh  = {rem_reg[DW-1:0], dvd_reg[DW-1]};
        rem_try = rem_sh - (DW+1)'(dvs_reg);
        q_signed = neg_reg ? -64'(q_reg) : 64'(q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
            neg_reg  <= 1'b0;
            dvd_reg  <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quot     <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
                neg_reg  <= num[kpva_pkg::WORD_W-1] ^ den[kpva_pkg::WORD_W-1];
                dvd_reg  <= num_mag;
                dvs_reg  <= den_mag;
                rem_reg  <= '0;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    // All quotient bits are in; apply the sign and saturate.
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                    quot     <= kpva_pkg::sat64(q_signed);
                end
                else
                begin
                    dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                    if (!rem_try[DW])
                    begin
                        rem_reg <= rem_try;
                        q_reg   <= {q_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[DW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/kalman_pos_vel_acc_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// A clear shows its result in the cycle after the transaction; a predict runs
// 27 steps on the shared unit, an update 29 steps plus three gain divisions,
// and an update whose innovation variance s is zero is skipped once s is computed.
// One transaction at a time: s_axis_tready is low until the result is taken,
// so a new item is not accepted before the last result has been taken.
// Reset (rst_n, asynchronous) zeroes estimate, covariance and noise registers.
// ----------------------------------------------------------------------------
// kalman_pos_vel_acc_tracker: three-state Kalman tracker
// Sequencer driving one shared saturating ALU and one iterative divider.
// ----------------------------------------------------------------------------
module kalman_pos_vel_acc_tracker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] value, [62:32] meas_variance, zero fill
    input  wire logic [63:0] s_axis_tdata,
    // [1:0] op
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] position, [63:32] velocity, [95:64] acceleration
    output logic [95:0]      m_axis_tdata,
    // [0] update_skipped
    output logic             m_axis_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data
);

    localparam int W = kpva_pkg::WORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_DIV,
        S_DIVWAIT,
        S_OUT
    } state_t;

    // Micro-op: dst := src_a OP src_b over a small register file.
    // File: 0..2 estimate, 3..11 covariance, 12 dt/meas, 13 var, 14..16 q,
    // 17 scratch t, 18 y, 19..21 k, 22..24 old row, 25 zero.
    typedef struct packed {
        kpva_pkg::alu_op_t op;
        logic [4:0] a;
        logic [4:0] b;
        logic [4:0] d;
    } uop_t;

    localparam logic [4:0] R_IN  = 5'd12;
    localparam logic [4:0] R_VAR = 5'd13;
    localparam logic [4:0] R_Q0  = 5'd14;
    localparam logic [4:0] R_T   = 5'd17;
    localparam logic [4:0] R_Y   = 5'd18;
    localparam logic [4:0] R_K0  = 5'd19;
    localparam logic [4:0] R_RW0 = 5'd22;
    localparam logic [4:0] R_Z   = 5'd25;
    localparam int NREG = 26;

    logic signed [W-1:0] rf_reg [NREG];
    state_t state_reg;
    logic [1:0] op_reg;
    logic [5:0] pc_reg;
    logic [1:0] kidx_reg;
    logic skip_reg;
    logic [30:0] q_reg [3];

    uop_t uop;
    logic last_uop;
    kpva_pkg::alu_req_t req;
    logic signed [W-1:0] alu_y;
    logic div_start;
    logic div_done;
    logic signed [W-1:0] div_q;
    logic [4:0] rr;
    logic [4:0] rd;
    logic [4:0] ci;
    logic [4:0] cj;

    // Row register index of p[r][r], r = op.
    assign rr = 5'd3 + 5'(op_reg) * 5'd4;

    function automatic uop_t mk(input kpva_pkg::alu_op_t o, input logic [4:0] a,
                                input logic [4:0] b, input logic [4:0] d);
        uop_t u;
        u.op = o; u.a = a; u.b = b; u.d = d;
        return u;
    endfunction

    always_comb
    begin
        uop = mk(kpva_pkg::ALU_ADD, R_Z, R_Z, R_T);
        last_uop = 1'b0;
        rd = 5'd0;
        ci = 5'd0;
        cj = 5'd0;
        if (op_reg == kpva_pkg::OP_PREDICT)
        begin
            case (pc_reg)
                6'd0:  uop = mk(kpva_pkg::ALU_MUL, 5'd1, R_IN, R_T);
                6'd1:  uop = mk(kpva_pkg::ALU_ADD, 5'd0, R_T, 5'd0);
                6'd2:  uop = mk(kpva_pkg::ALU_MUL, 5'd2, R_IN, R_T);
                6'd3:  uop = mk(kpva_pkg::ALU_ADD, 5'd1, R_T, 5'd1);
                6'd4:  uop = mk(kpva_pkg::ALU_ADD, 5'd4, 5'd6, R_T);
                6'd5:  uop = mk(kpva_pkg::ALU_MUL, R_T, R_IN, R_T);
                6'd6:  uop = mk(kpva_pkg::ALU_ADD, R_T, R_Q0, R_T);
                6'd7:  uop = mk(kpva_pkg::ALU_ADD, 5'd3, R_T, 5'd3);
                6'd8:  uop = mk(kpva_pkg::ALU_ADD, 5'd5, 5'd7, R_T);
                6'd9:  uop = mk(kpva_pkg::ALU_MUL, R_T, R_IN, R_T);
                6'd10: uop = mk(kpva_pkg::ALU_ADD, 5'd4, R_T, 5'd4);
                6'd11: uop = mk(kpva_pkg::ALU_MUL, 5'd8, R_IN, R_T);
                6'd12: uop = mk(kpva_pkg::ALU_ADD, 5'd5, R_T, 5'd5);
                6'd13: uop = mk(kpva_pkg::ALU_ADD, 5'd7, 5'd9, R_T);
                6'd14: uop = mk(kpva_pkg::ALU_MUL, R_T, R_IN, R_T);
                6'd15: uop = mk(kpva_pkg::ALU_ADD, 5'd6, R_T, 5'd6);
                6'd16: uop = mk(kpva_pkg::ALU_ADD, 5'd8, 5'd10, R_T);
                6'd17: uop = mk(kpva_pkg::ALU_MUL, R_T, R_IN, R_T);
                6'd18: uop = mk(kpva_pkg::ALU_ADD, R_T, 5'd15, R_T);
                6'd19: uop = mk(kpva_pkg::ALU_ADD, 5'd7, R_T, 5'd7);
                6'd20: uop = mk(kpva_pkg::ALU_MUL, 5'd11, R_IN, R_T);
                6'd21: uop = mk(kpva_pkg::ALU_ADD, 5'd8, R_T, 5'd8);
                6'd22: uop = mk(kpva_pkg::ALU_MUL, 5'd10, R_IN, R_T);
                6'd23: uop = mk(kpva_pkg::ALU_ADD, 5'd9, R_T, 5'd9);
                6'd24: uop = mk(kpva_pkg::ALU_MUL, 5'd11, R_IN, R_T);
                6'd25: uop = mk(kpva_pkg::ALU_ADD, 5'd10, R_T, 5'd10);
                default:
                begin
                    uop = mk(kpva_pkg::ALU_ADD, 5'd11, 5'd16, 5'd11);
                    last_uop = 1'b1;
                end
            endcase
        end
        else
        begin
            // Update: pc 0 y, 1 s, 2..4 copy old row, then (after gains)
            // 5..10 estimate, 11..28 covariance as multiply/subtract pairs.
            case (pc_reg)
                6'd0: uop = mk(kpva_pkg::ALU_SUB, R_IN, 5'(op_reg), R_Y);
                6'd1: uop = mk(kpva_pkg::ALU_ADD, rr, R_VAR, R_T);
                6'd2: uop = mk(kpva_pkg::ALU_ADD, 5'd3 + 5'(op_reg) * 5'd3, R_Z, R_RW0);
                6'd3: uop = mk(kpva_pkg::ALU_ADD, 5'd4 + 5'(op_reg) * 5'd3, R_Z,
                               R_RW0 + 5'd1);
                6'd4: uop = mk(kpva_pkg::ALU_ADD, 5'd5 + 5'(op_reg) * 5'd3, R_Z,
                               R_RW0 + 5'd2);
                6'd5, 6'd7, 6'd9:
                begin
                    rd = 5'((pc_reg - 6'd5) >> 1);
                    uop = mk(kpva_pkg::ALU_MUL, R_K0 + rd, R_Y, R_T);
                end
                6'd6, 6'd8, 6'd10:
                begin
                    rd = 5'((pc_reg - 6'd6) >> 1);
                    uop = mk(kpva_pkg::ALU_ADD, rd, R_T, rd);
                end
                default:
                begin
                    // Pairs for covariance entry e = (pc-11)/2, row ci, column cj.
                    rd = 5'((pc_reg - 6'd11) >> 1);
                    case (rd)
                        5'd0, 5'd1, 5'd2: ci = 5'd0;
                        5'd3, 5'd4, 5'd5: ci = 5'd1;
                        default:          ci = 5'd2;
                    endcase
                    cj = rd - (ci + (ci << 1));
                    if (pc_reg[0])
                        uop = mk(kpva_pkg::ALU_MUL, R_RW0 + cj, R_K0 + ci, R_T);
                    else
                        uop = mk(kpva_pkg::ALU_SUB, 5'd3 + rd, R_T, 5'd3 + rd);
                    last_uop = (pc_reg == 6'd28);
                end
            endcase
        end
    end

    assign req = '{start: (state_reg == S_ISSUE), op: uop.op,
                   a: rf_reg[uop.a], b: rf_reg[uop.b]};

    kpva_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .result (alu_y)
    );

    // The divider gets s from the scratch register and p[i][r].
    assign div_start = (state_reg == S_DIV);

    kpva_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rf_reg[5'd3 + 5'(kidx_reg) * 5'd3 + 5'(op_reg)]),
        .den   (rf_reg[R_T]),
        .done  (div_done),
        .quot  (div_q)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {rf_reg[2], rf_reg[1], rf_reg[0]};
    assign m_axis_tuser  = skip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            pc_reg    <= '0;
            kidx_reg  <= '0;
            skip_reg  <= 1'b0;
            for (int i = 0; i < NREG; i++)
                rf_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
                q_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    kpva_pkg::CFG_NOISE_POS: q_reg[0] <= cfg_data;
                    kpva_pkg::CFG_NOISE_VEL: q_reg[1] <= cfg_data;
                    kpva_pkg::CFG_NOISE_ACC: q_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg     <= s_axis_tuser;
                        rf_reg[R_IN]  <= s_axis_tdata[31:0];
                        rf_reg[R_VAR] <= {1'b0, s_axis_tdata[62:32]};
                        rf_reg[R_Q0]  <= {1'b0, q_reg[0]};
                        rf_reg[15]    <= {1'b0, q_reg[1]};
                        rf_reg[16]    <= {1'b0, q_reg[2]};
                        pc_reg     <= '0;
                        kidx_reg   <= '0;
                        skip_reg   <= 1'b0;
                        if (s_axis_tuser == kpva_pkg::OP_CLEAR)
                        begin
                            for (int i = 0; i < 12; i++)
                                rf_reg[i] <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    rf_reg[uop.d] <= alu_y;
                    pc_reg <= pc_reg + 1'b1;
                    if (last_uop)
                        state_reg <= S_OUT;
                    else if (op_reg != kpva_pkg::OP_PREDICT && pc_reg == 6'd1
                             && alu_y == '0)
                    begin
                        skip_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (op_reg != kpva_pkg::OP_PREDICT && pc_reg == 6'd4)
                        state_reg <= S_DIV;
                    else
                        state_reg <= S_ISSUE;
                end
                S_DIV:
                begin
                    state_reg <= S_DIVWAIT;
                end
                S_DIVWAIT:
                begin
                    if (div_done)
                    begin
                        rf_reg[R_K0 + 5'(kidx_reg)] <= div_q;
                        kidx_reg <= kidx_reg + 1'b1;
                        state_reg <= (kidx_reg == 2'd2) ? S_ISSUE : S_DIV;
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/kpva_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpva_checker: port-level assertions for the tracker
// Checks the stream handshakes and the one-at-a-time behavior.
// ----------------------------------------------------------------------------
module kpva_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // A stalled result holds its data and its flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Never ready for input while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready with result pending");

    // An accepted input leaves the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");

    // A result is presented only once.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("result repeated");

endmodule

bind kalman_pos_vel_acc_tracker kpva_checker u_kpva_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
